### rtl/core/base64_stream_decoder_macros.svh
// Assertion macros for the Base64 stream decoder.
// Checks compile away when SYNTHESIS is defined; no other dependencies.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH
`ifndef SYNTHESIS
// Condition that must hold on every clock edge out of reset.
`define B64_ASSERT_ALWAYS(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define B64_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define B64_ASSERT_ALWAYS(name, clk, rst, cond, msg)
`define B64_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/core/b64sd_pkg.sv
// Shared types, codes and the character classifier for the Base64 stream decoder.
// No dependencies.
package b64sd_pkg;

  localparam int COUNT_BITS = 16;

  // classifier codes above the 64 alphabet values
  localparam logic [6:0] SX_WS  = 7'd64;
  localparam logic [6:0] SX_PAD = 7'd65;
  localparam logic [6:0] SX_BAD = 7'd66;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR  = 3'd1;
  localparam logic [2:0] ST_BAD_PAD   = 3'd2;
  localparam logic [2:0] ST_MISS_PAD  = 3'd3;
  localparam logic [2:0] ST_PARTIAL   = 3'd4;
  localparam logic [2:0] ST_COUNT_OVF = 3'd5;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [2:0]  status;
    logic [15:0] count;
    logic        last;
  } result_t;

  function automatic logic [6:0] classify(input logic [7:0] c);
    logic [6:0] v;
    if (c == 8'h0D || c == 8'h0A || c == 8'h09 || c == 8'h20) v = SX_WS;
    else if (c == 8'h3D) v = SX_PAD;                                  // '='
    else if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);             // A-Z
    else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);     // a-z
    else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);     // 0-9
    else if (c == 8'h2B) v = 7'd62;                                   // '+'
    else if (c == 8'h2F) v = 7'd63;                                   // '/'
    else v = SX_BAD;
    return v;
  endfunction

endpackage

### rtl/core/base64_stream_decoder.sv
// A character is taken into the input register and decoded there combinationally; its
// results are loaded into the group register, which drives the master side.
// Throughput: one character per cycle unless it waits for the group; results leave one per
// cycle while m_tready is high from a four-slot group register, and a character that yields
// results waits until the group is empty or its last result is taken in that same cycle.
// Reset (rst, synchronous, active high) clears the decoder state, the input valid flag and the group fill and index.
// Uses b64sd_pkg and base64_stream_decoder_macros.svh.
`include "base64_stream_decoder_macros.svh"

module base64_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] data_byte, [10:8] status, [26:11] byte_count
  output logic        m_tuser,   // kind
  output logic        m_tlast    // last_result
);

  localparam logic [b64sd_pkg::COUNT_BITS-1:0] CountMax = '1;

  // input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;

  // decoder state
  logic [17:0] accum, accum_next;
  logic [1:0]  held, held_next;
  logic        tail, tail_next;
  logic        pexp, pexp_next;
  logic        pseen, pseen_next;
  logic [2:0]  err, err_next;
  logic [b64sd_pkg::COUNT_BITS-1:0] cnt, cnt_next;

  // result group
  b64sd_pkg::result_t grp [4];
  logic [2:0] grp_n;
  logic [2:0] grp_idx;
  logic [2:0] pending;
  logic       grp_free;
  logic       process;

  b64sd_pkg::result_t res [4];
  logic [2:0] res_n;
  logic [2:0] nb;
  logic [7:0] cand [3];
  logic [1:0] cand_n;
  logic [6:0] v;
  logic [23:0] quad;
  logic [2:0]  st;
  logic [b64sd_pkg::COUNT_BITS+15:0] cnt_ext;

  always_comb begin
    v          = b64sd_pkg::classify(in_char);
    quad       = {accum, v[5:0]};
    accum_next = accum;
    held_next  = held;
    tail_next  = tail;
    pexp_next  = pexp;
    pseen_next = pseen;
    err_next   = err;
    cnt_next   = cnt;
    cand[0]    = 8'd0;
    cand[1]    = 8'd0;
    cand[2]    = 8'd0;
    cand_n     = 2'd0;
    nb         = 3'd0;
    st         = b64sd_pkg::ST_OK;
    cnt_ext    = '0;

    if (err == b64sd_pkg::ST_OK && v != b64sd_pkg::SX_WS) begin
      if (v == b64sd_pkg::SX_BAD) begin
        err_next = b64sd_pkg::ST_BAD_CHAR;
      end else if (tail) begin
        if (v == b64sd_pkg::SX_PAD && pexp && !pseen) pseen_next = 1'b1;
        else err_next = b64sd_pkg::ST_BAD_PAD;
      end else if (v == b64sd_pkg::SX_PAD) begin
        if (held == 2'd2 || held == 2'd3) begin
          if (held == 2'd2) begin
            cand[0]   = accum[11:4];
            cand_n    = 2'd1;
            pexp_next = 1'b1;
          end else begin
            cand[0]   = accum[17:10];
            cand[1]   = accum[9:2];
            cand_n    = 2'd2;
            pexp_next = 1'b0;
          end
          tail_next  = 1'b1;
          pseen_next = 1'b0;
          held_next  = 2'd0;
          accum_next = '0;
        end else begin
          err_next = b64sd_pkg::ST_BAD_PAD;
        end
      end else if (held == 2'd3) begin
        cand[0]    = quad[23:16];
        cand[1]    = quad[15:8];
        cand[2]    = quad[7:0];
        cand_n     = 2'd3;
        held_next  = 2'd0;
        accum_next = '0;
      end else begin
        accum_next = quad[17:0];
        held_next  = held + 2'd1;
      end
    end

    // bytes go out in order until the count saturates
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < cand_n && err_next == b64sd_pkg::ST_OK) begin
        if (cnt_next == CountMax) begin
          err_next = b64sd_pkg::ST_COUNT_OVF;
        end else begin
          cnt_next = cnt_next + 1'b1;
          nb       = 3'(i + 1);
        end
      end
    end

    st = err_next;
    if (st == b64sd_pkg::ST_OK) begin
      if (tail_next) begin
        if (pexp_next && !pseen_next) st = b64sd_pkg::ST_MISS_PAD;
      end else if (held_next != 2'd0) begin
        st = b64sd_pkg::ST_PARTIAL;
      end
    end
    cnt_ext = (b64sd_pkg::COUNT_BITS+16)'(cnt_next);
    res_n   = nb + {2'd0, in_last};

    for (int k = 0; k < 4; k++) begin
      res[k] = '0;
      if (3'(k) < nb) begin
        res[k].kind = b64sd_pkg::KIND_DATA;
        res[k].data = cand[k % 3];
      end else if (3'(k) == nb && in_last) begin
        res[k].kind   = b64sd_pkg::KIND_STATUS;
        res[k].status = st;
        res[k].count  = cnt_ext[15:0];
      end
      res[k].last = (3'(k) == res_n - 3'd1);
    end

    // message closed: back to reset state
    if (in_last) begin
      accum_next = '0;
      held_next  = 2'd0;
      tail_next  = 1'b0;
      pexp_next  = 1'b0;
      pseen_next = 1'b0;
      err_next   = b64sd_pkg::ST_OK;
      cnt_next   = '0;
    end
  end

  assign pending  = grp_n - grp_idx;
  assign m_tvalid = (pending != 3'd0);
  assign grp_free = (pending == 3'd0) || (pending == 3'd1 && m_tready);
  assign process  = in_valid && (res_n == 3'd0 || grp_free);
  assign s_tready = !in_valid || process;

  assign m_tdata = {5'd0, grp[grp_idx[1:0]].count, grp[grp_idx[1:0]].status,
                    grp[grp_idx[1:0]].data};
  assign m_tuser = grp[grp_idx[1:0]].kind;
  assign m_tlast = grp[grp_idx[1:0]].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      grp_n    <= 3'd0;
      grp_idx  <= 3'd0;
      accum    <= '0;
      held     <= 2'd0;
      tail     <= 1'b0;
      pexp     <= 1'b0;
      pseen    <= 1'b0;
      err      <= b64sd_pkg::ST_OK;
      cnt      <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
        if (s_tvalid) begin
          in_char <= s_tdata;
          in_last <= s_tlast;
        end
      end
      if (process) begin
        accum <= accum_next;
        held  <= held_next;
        tail  <= tail_next;
        pexp  <= pexp_next;
        pseen <= pseen_next;
        err   <= err_next;
        cnt   <= cnt_next;
      end
      if (process && res_n != 3'd0) begin
        for (int k = 0; k < 4; k++) grp[k] <= res[k];
        grp_n   <= res_n;
        grp_idx <= 3'd0;
      end else if (m_tvalid && m_tready) begin
        grp_idx <= grp_idx + 3'd1;
      end
    end
  end

  `B64_ASSERT_ALWAYS(a_grp_bounds, clk, rst, grp_idx <= grp_n && grp_n <= 3'd4, "group index past fill")
  `B64_ASSERT_NEXT(a_grp_continues, clk, rst, m_tvalid && m_tready && !m_tlast, m_tvalid, "group ended without last")
  `B64_ASSERT_NEXT(a_msg_reset, clk, rst, process && in_last, held == 2'd0 && cnt == '0 && err == b64sd_pkg::ST_OK && !tail, "state not cleared after end mark")
  `B64_ASSERT_ALWAYS(a_data_clean, clk, rst, !(m_tvalid && m_tuser == b64sd_pkg::KIND_DATA) || m_tdata[26:8] == 19'd0, "data result carries status fields")

endmodule
